>>> rtl/core/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the decimal text formatter
// Holds the word that travels down the conversion chain, the field widths
// and the ASCII codes used by the character emitter.
// ----------------------------------------------------------------------------
package sida_pkg;

    // Width of the signed input value and of its magnitude.
    localparam int BIN_W = 32;

    // Number of decimal digits needed for a 32-bit magnitude.
    localparam int DIGITS = 10;

    // Packed BCD field, four bits a digit.
    localparam int BCD_W = 4 * DIGITS;

    // One conversion cell per magnitude bit.
    localparam int STEPS = BIN_W;

    // Width of a digit position index.
    localparam int POS_W = $clog2(DIGITS);

    // Width of an output character.
    localparam int CHAR_W = 7;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    // Word handed from cell to cell along the chain.
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [BIN_W-1:0]   bin;
    } word_t;

endpackage

>>> rtl/core/sida_cell.sv
// ----------------------------------------------------------------------------
// sida_cell: one shift-and-add-3 conversion cell
// Corrects every BCD digit of the incoming word that is five or more, then
// shifts the next magnitude bit into the BCD field, and registers the result.
// ----------------------------------------------------------------------------
module sida_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  sida_pkg::word_t d,
    output sida_pkg::word_t q
);

    logic                          valid_reg;
    logic                          neg_reg;
    logic [sida_pkg::BCD_W-1:0]    bcd_reg;
    logic [sida_pkg::BIN_W-1:0]    bin_reg;
    sida_pkg::word_t               q_next;
    logic [sida_pkg::BCD_W-1:0]    corr;

    // Add three to each digit of five or more, so the shift carries correctly.
    always_comb
    begin
        for (int i = 0; i < sida_pkg::DIGITS; i++)
        begin
            if (d.bcd[4*i +: 4] >= 4'd5)
            begin
                corr[4*i +: 4] = d.bcd[4*i +: 4] + 4'd3;
            end
            else
            begin
                corr[4*i +: 4] = d.bcd[4*i +: 4];
            end
        end
    end

    // Shift the top magnitude bit into the digits.
    always_comb
    begin
        q_next.valid = d.valid;
        q_next.neg   = d.neg;
        q_next.bcd   = {corr[sida_pkg::BCD_W-2:0], d.bin[sida_pkg::BIN_W-1]};
        q_next.bin   = {d.bin[sida_pkg::BIN_W-2:0], 1'b0};
    end

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= q_next.valid;
        end
    end

    // The payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= q_next.neg;
            bcd_reg <= q_next.bcd;
            bin_reg <= q_next.bin;
        end
    end

    assign q = {valid_reg, neg_reg, bcd_reg, bin_reg};

endmodule

>>> rtl/core/sida_emit.sv
// ----------------------------------------------------------------------------
// sida_emit: character emitter
// Takes a converted word from the end of the chain and sends its text one
// character a cycle while out_ready is high: an optional minus sign, then
// the digits from the first significant one down to the ones digit.
// ----------------------------------------------------------------------------
module sida_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sida_pkg::word_t               d,
    output logic                          load,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   character,
    output logic                          last_char
);

    logic [sida_pkg::BCD_W-1:0]   digits_reg;
    logic [sida_pkg::BCD_W-1:0]   digits_next;
    logic                         neg_reg;
    logic                         neg_next;
    logic [sida_pkg::POS_W-1:0]   pos_reg;
    logic [sida_pkg::POS_W-1:0]   pos_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic [sida_pkg::POS_W-1:0]   first_pos;
    logic [3:0]                   digit;
    logic                         take;
    logic                         is_last;

    // Position of the most significant non-zero digit; the ones digit if all are zero.
    always_comb
    begin
        first_pos = '0;
        for (int i = 1; i < sida_pkg::DIGITS; i++)
        begin
            if (d.bcd[4*i +: 4] != 4'd0)
            begin
                first_pos = sida_pkg::POS_W'(i);
            end
        end
    end

    // Current character and handshake.
    assign digit     = digits_reg[4*pos_reg +: 4];
    assign is_last   = !neg_reg && (pos_reg == '0);
    assign out_valid = busy_reg;
    assign character = neg_reg ? sida_pkg::CHAR_MINUS
                               : sida_pkg::CHAR_ZERO + {3'b000, digit};
    assign last_char = is_last;
    assign take      = busy_reg && out_ready;

    // A new word is taken when idle or as the last character of the run leaves.
    assign load = d.valid && (!busy_reg || (take && is_last));

    // Next-state logic for the run in progress.
    always_comb
    begin
        digits_next = digits_reg;
        neg_next    = neg_reg;
        pos_next    = pos_reg;
        busy_next   = busy_reg;
        if (take)
        begin
            if (neg_reg)
            begin
                neg_next = 1'b0;
            end
            else if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - 1'b1;
            end
        end
        if (load)
        begin
            busy_next   = 1'b1;
            digits_next = d.bcd;
            neg_next    = d.neg;
            pos_next    = first_pos;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            neg_reg  <= neg_next;
            pos_reg  <= pos_next;
        end
    end

    // Digit store.
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

    // A digit shown is always a decimal digit.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !neg_reg) |-> (digit <= 4'd9))
        else $error("emitter shows a digit above nine");

    // The position never leaves the digit field.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= sida_pkg::POS_W'(sida_pkg::DIGITS - 1)))
        else $error("emitter position out of range");

    // A run does not break off before its last character.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last) |=> busy_reg)
        else $error("emitter run ended early");

    // A minus sign is only ever the first character of a run.
    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !neg_reg && !load) |=> !neg_reg)
        else $error("minus sign after a digit");

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal text
// Each word passes through the 32 registered cells of the chain, then is
// loaded by the emitter, which offers its first character. Throughput: one
// character a cycle while out_ready is high; a word's text is 1 to 11
// characters at the single output port, and the 32-cell chain takes a new
// word every cycle while the emitter keeps up.
// Reset clears the chain's valid flags and the emitter's control state only.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sida_pkg::CHAR_W-1:0]   character,
    output logic                          last_char
);

    sida_pkg::word_t                chain [0:sida_pkg::STEPS];
    logic [sida_pkg::BIN_W-1:0]     raw;
    logic [sida_pkg::BIN_W-1:0]     mag;
    logic                           advance;
    logic                           load;

    // Magnitude and sign of the incoming word.
    assign raw = $unsigned(value);
    assign mag = raw[sida_pkg::BIN_W-1] ? (~raw + 1'b1) : raw;

    always_comb
    begin
        chain[0].valid = in_valid;
        chain[0].neg   = raw[sida_pkg::BIN_W-1];
        chain[0].bcd   = '0;
        chain[0].bin   = mag;
    end

    // The chain moves whenever its end is empty or handed on.
    assign advance  = !chain[sida_pkg::STEPS].valid || load;
    assign in_ready = advance;

    // One shift-and-add-3 cell per magnitude bit.
    for (genvar g = 0; g < sida_pkg::STEPS; g++)
    begin : g_cell
        sida_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (advance),
            .d     (chain[g]),
            .q     (chain[g+1])
        );
    end

    // Serial character output.
    sida_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .d         (chain[sida_pkg::STEPS]),
        .load      (load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the signed integer to decimal text unit
// Feeds signed 32-bit words and checks each returned character word against
// typed text or a decimal formatter in the bench. A short table of directed
// values comes first, then random values in bursts, while the output side
// stalls on its own pattern, including one long hold that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int        HALF_PERIOD   = 5;
    localparam int        RANDOM_VALUES = 150;
    localparam int        PAUSE_AT      = 75;
    localparam int        HOLD_AFTER    = 50;
    localparam int        HOLD_CYCLES   = 300;
    localparam int        SETTLE_CYCLES = 40;
    localparam int        IDLE_LIMIT    = 4000;
    localparam int        REPORT_LIMIT  = 10;
    localparam logic [31:0] TOP_SCALE   = 32'd1_000_000_000;

    // One expected character word.
    typedef struct packed {
        logic [sida_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_char_t;

    // One directed value; an empty text means the formatter supplies it.
    typedef struct {
        logic signed [31:0] num;
        string              txt;
    } value_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [31:0]              value;
    logic                            out_valid;
    logic                            out_ready;
    logic [sida_pkg::CHAR_W-1:0]     character;
    logic                            last_char;

    text_char_t pending_chars[$];
    int         values_sent;
    int         negatives_sent;
    int         longest_texts;
    int         chars_checked;
    int         fail_count;
    int         idle_cycles;

    value_row_t directed_rows [] = '{
        '{32'sd0,            "0"},
        '{32'sd1,            "1"},
        '{-32'sd1,           "-1"},
        '{32'sd9,            "9"},
        '{32'sd10,           "10"},
        '{-32'sd10,          "-10"},
        '{32'sd2147483647,   "2147483647"},
        '{32'h8000_0000,     "-2147483648"},
        '{-32'sd2147483647,  "-2147483647"},
        '{32'sd1000000000,   "1000000000"},
        '{32'sd999999999,    "999999999"},
        '{32'sd99,           ""},
        '{32'sd100,          ""},
        '{32'sd10000,        ""},
        '{-32'sd100000,      ""},
        '{32'sd1000000001,   ""},
        '{32'sd123456789,    ""},
        '{-32'sd987654321,   ""},
        '{32'h5555_5555,     ""},
        '{32'hAAAA_AAAA,     ""}
    };

    signed_int_to_decimal_ascii_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Decimal formatter: appends the expected text of one value.
    function automatic void format_decimal(input logic signed [31:0] num);
        logic [31:0] magnitude;
        logic [31:0] scale;
        logic [3:0]  digit;
        bit          started;
        int          length;
        started = 1'b0;
        length  = 0;
        scale   = TOP_SCALE;
        magnitude = num[31] ? (32'd0 - num) : num;
        if (num[31])
        begin
            pending_chars.push_back('{sida_pkg::CHAR_MINUS, 1'b0});
            length++;
        end
        for (int pos = 0; pos < sida_pkg::DIGITS; pos++)
        begin
            digit = 4'((magnitude / scale) % 32'd10);
            if (digit != 4'd0 || started || scale == 32'd1)
            begin
                started = 1'b1;
                pending_chars.push_back('{sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digit),
                                          scale == 32'd1});
                length++;
            end
            scale = scale / 32'd10;
        end
        if (length == sida_pkg::DIGITS + 1)
            longest_texts++;
    endfunction

    // Appends a text typed into the directed table.
    function automatic void expect_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            pending_chars.push_back('{sida_pkg::CHAR_W'(txt[i]), i == txt.len() - 1});
        if (txt.len() == sida_pkg::DIGITS + 1)
            longest_texts++;
    endfunction

    // Offers one word and holds it until taken; leaves valid high.
    task automatic send_value(input logic signed [31:0] num, input string txt);
        in_valid <= 1'b1;
        value    <= num;
        do
            @(posedge clk);
        while (!in_ready);
        values_sent++;
        if (num[31])
            negatives_sent++;
        if (txt.len() > 0)
            expect_text(txt);
        else
            format_decimal(num);
        @(negedge clk);
    endtask

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_chars.size() > 0)
            @(negedge clk);
    endtask

    // Random value: full range, short magnitudes, or near a power of ten.
    function automatic logic signed [31:0] random_value();
        logic [31:0] num;
        int          exponent;
        case ($urandom_range(0, 2))
            0: num = $urandom;
            1: num = $urandom >> $urandom_range(1, 31);
            default:
            begin
                exponent = $urandom_range(0, 9);
                num = 32'd1;
                repeat (exponent) num = num * 32'd10;
                num = num - 32'($urandom_range(0, 1));
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            num = 32'd0 - num;
        return num;
    endfunction

    // Stimulus and end of run.
    initial
    begin : sender
        int burst;
        int sent_random;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        values_sent    = 0;
        negatives_sent = 0;
        longest_texts  = 0;
        sent_random    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, back to back, then wait for the full output.
        foreach (directed_rows[i])
            send_value(directed_rows[i].num, directed_rows[i].txt);
        wait_drained();

        // Random bursts with random gaps, one pause midway until drained.
        while (sent_random < RANDOM_VALUES)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent_random < RANDOM_VALUES; k++)
            begin
                send_value(random_value(), "");
                sent_random++;
                if (sent_random == PAUSE_AT)
                    wait_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 15));
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (pending_chars.size() > 0)
            fail_count++;
        $display("Formatted %0d values (%0d negative, %0d of eleven characters).",
                 values_sent, negatives_sent, longest_texts);
        $display("Checked %0d characters under output stalls and one long hold.",
                 chars_checked);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Output side: stalls on its own pattern, with one long hold once the
    // input has got going, so that the chain fills and stops taking words.
    initial
    begin : receiver
        int  mode;
        int  seg_left;
        int  hold_left;
        bit  hold_done;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && values_sent >= directed_rows.size() + HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 60);
                end
                seg_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compares each accepted character word with the oldest expectation.
    initial
    begin
        chars_checked = 0;
        fail_count    = 0;
    end

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected character %0d last=%0b",
                             $realtime, character, last_char);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (character !== want.code || last_char !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: character %0d: expected %0d last=%0b, got %0d last=%0b",
                                 $realtime, chars_checked, want.code, want.last,
                                 character, last_char);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    initial idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timed out with %0d characters outstanding.", pending_chars.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/core/sida_pkg.sv
rtl/core/sida_cell.sv
rtl/core/sida_emit.sv
rtl/core/signed_int_to_decimal_ascii_unit.sv
dv/tb_top.sv
